[hw/rtl/tte_pkg.sv]
// Package: item class codes, opcode constants and the Thumb-to-ARM expansion function.
package tte_pkg;

    typedef enum logic [3:0] {
        CLS_ALU    = 4'd0,
        CLS_MUL    = 4'd1,
        CLS_BX     = 4'd2,
        CLS_SINGLE = 4'd3,
        CLS_HALF   = 4'd4,
        CLS_BLOCK  = 4'd5,
        CLS_BRANCH = 4'd6,
        CLS_SWI    = 4'd7,
        CLS_NONE   = 4'd8
    } cls_t;

    typedef struct packed {
        logic [31:0] word;
        cls_t        cls;
    } expand_t;

    // ARM data-processing opcodes
    localparam logic [3:0] OP_SUB = 4'h2;
    localparam logic [3:0] OP_ADD = 4'h4;
    localparam logic [3:0] OP_CMP = 4'hA;
    localparam logic [3:0] OP_MOV = 4'hD;

    // Thumb ALU-group opcodes with special handling
    localparam logic [3:0] ALU_LSL = 4'h2;
    localparam logic [3:0] ALU_LSR = 4'h3;
    localparam logic [3:0] ALU_ASR = 4'h4;
    localparam logic [3:0] ALU_ROR = 4'h7;
    localparam logic [3:0] ALU_NEG = 4'h9;
    localparam logic [3:0] ALU_MUL = 4'hD;

    localparam logic [3:0] COND_NEVER = 4'hE;
    localparam logic [3:0] COND_SWI   = 4'hF;

    // Immediate-op opcodes: MOV, CMP, ADD, SUB
    function automatic logic [3:0] imm_op(input logic [1:0] sel);
        logic [3:0] r;
        unique case (sel)
            2'd0:    r = OP_MOV;
            2'd1:    r = OP_CMP;
            2'd2:    r = OP_ADD;
            default: r = OP_SUB;
        endcase
        return r;
    endfunction

    // Hi-register opcodes: ADD, CMP, MOV
    function automatic logic [3:0] hi_op(input logic [1:0] sel);
        logic [3:0] r;
        unique case (sel)
            2'd0:    r = OP_ADD;
            2'd1:    r = OP_CMP;
            default: r = OP_MOV;
        endcase
        return r;
    endfunction

    function automatic expand_t expand(input logic [15:0] t);
        expand_t    e;
        logic [4:0] top;
        logic [2:0] rd;
        logic [2:0] rb;
        logic [2:0] ro;
        logic [3:0] aop;
        logic [1:0] hop;
        logic [3:0] hrs;
        logic [3:0] hrd;
        logic [1:0] sh;
        logic [1:0] hsh;
        logic [6:0] off7;
        logic [5:0] off6;
        logic       l;
        logic [3:0] cond;
        top  = t[15:11];
        rd   = t[2:0];
        rb   = t[5:3];
        ro   = t[8:6];
        aop  = t[9:6];
        hop  = t[9:8];
        hrs  = {t[6], t[5:3]};
        hrd  = {t[7], t[2:0]};
        l    = t[11];
        cond = t[11:8];
        off7 = t[12] ? {2'b00, t[10:6]} : {t[10:6], 2'b00};
        off6 = {t[10:6], 1'b0};
        unique case (aop)
            ALU_LSL: sh = 2'd0;
            ALU_LSR: sh = 2'd1;
            ALU_ASR: sh = 2'd2;
            default: sh = 2'd3;
        endcase
        unique case (t[11:10])
            2'd0:    hsh = 2'd1;
            2'd1:    hsh = 2'd2;
            2'd2:    hsh = 2'd1;
            default: hsh = 2'd3;
        endcase
        e.word = 32'h0;
        e.cls  = CLS_NONE;
        unique case (top)
            5'd0, 5'd1, 5'd2:
            begin
                e.cls  = CLS_ALU;
                e.word = 32'hE1B00000 | {16'h0, 1'b0, rd, t[10:6], top[1:0], 2'b00, rb};
            end
            5'd3:
            begin
                e.cls  = CLS_ALU;
                e.word = 32'hE0100000 | {6'h0, t[10], (t[9] ? OP_SUB : OP_ADD),
                                         1'b0, 1'b0, rb, 1'b0, rd, 9'h0, ro};
            end
            5'd4, 5'd5, 5'd6, 5'd7:
            begin
                e.cls  = CLS_ALU;
                e.word = 32'hE2100000 | {7'h0, imm_op(top[1:0]), 1'b0,
                                         1'b0, t[10:8], 1'b0, t[10:8], 4'h0, t[7:0]};
            end
            5'd8:
            begin
                if (!t[10])
                begin
                    e.cls = CLS_ALU;
                    if (aop == ALU_LSL || aop == ALU_LSR || aop == ALU_ASR || aop == ALU_ROR)
                        e.word = 32'hE1B00010 | {16'h0, 1'b0, rd, 1'b0, rb, 1'b0, sh,
                                                 2'b00, rd};
                    else if (aop == ALU_NEG)
                        e.word = 32'hE2700000 | {12'h0, 1'b0, rb, 1'b0, rd, 12'h0};
                    else if (aop == ALU_MUL)
                    begin
                        e.cls  = CLS_MUL;
                        e.word = 32'hE0100090 | {12'h0, 1'b0, rd, 4'h0, 1'b0, rd, 5'h0, rb};
                    end
                    else
                        e.word = 32'hE0100000 | {7'h0, aop, 2'h0, rd, 1'b0, rd, 9'h0, rb};
                end
                else if (hop == 2'd3)
                begin
                    e.cls  = CLS_BX;
                    e.word = 32'hE12FFF10 | {28'h0, hrs};
                end
                else
                begin
                    e.cls  = CLS_ALU;
                    e.word = 32'hE0000000 | {7'h0, hi_op(hop), (hop == 2'd1), hrd, hrd,
                                             8'h0, hrs};
                end
            end
            5'd10, 5'd11:
            begin
                if (!t[9])
                begin
                    e.cls  = CLS_SINGLE;
                    e.word = 32'hE7800000 | {9'h0, t[10], 1'b0, t[11], 1'b0, rb, 1'b0, rd,
                                             9'h0, ro};
                end
                else
                begin
                    e.cls  = CLS_HALF;
                    e.word = 32'hE1800090 | {11'h0, (t[11:10] != 2'd0), 1'b0, rb, 1'b0, rd,
                                             5'h0, hsh, 2'b00, ro};
                end
            end
            5'd12, 5'd13, 5'd14, 5'd15:
            begin
                e.cls  = CLS_SINGLE;
                e.word = 32'hE5800000 | {9'h0, t[12], 1'b0, t[11], 1'b0, rb, 1'b0, rd,
                                         5'h0, off7};
            end
            5'd16, 5'd17:
            begin
                e.cls  = CLS_HALF;
                e.word = 32'hE1C000B0 | {11'h0, t[11], 1'b0, rb, 1'b0, rd, 2'b00,
                                         off6[5:4], 4'h0, off6[3:0]};
            end
            5'd18, 5'd19:
            begin
                e.cls  = CLS_SINGLE;
                e.word = 32'hE58D0000 | {11'h0, t[11], 5'h0, t[10:8], 2'b00, t[7:0], 2'b00};
            end
            5'd22, 5'd23:
            begin
                if (t[11:8] == 4'h0)
                begin
                    e.cls  = CLS_ALU;
                    e.word = 32'hE20DDF00 | {7'h0, (t[7] ? OP_SUB : OP_ADD), 14'h0,
                                             t[6:0]};
                end
                else if (t[10:9] == 2'd2)
                begin
                    e.cls  = CLS_BLOCK;
                    e.word = 32'hE82D0000 | {7'h0, ~l, l, 2'b00, l, 4'h0,
                                             (l & t[8]), (~l & t[8]), 6'h0, t[7:0]};
                end
            end
            5'd24, 5'd25:
            begin
                e.cls  = CLS_BLOCK;
                e.word = 32'hE8A00000 | {11'h0, t[11], 1'b0, t[10:8], 8'h0, t[7:0]};
            end
            5'd26, 5'd27:
            begin
                if (cond == COND_SWI)
                begin
                    e.cls  = CLS_SWI;
                    e.word = 32'hEF000000 | {24'h0, t[7:0]};
                end
                else if (cond != COND_NEVER)
                begin
                    e.cls  = CLS_BRANCH;
                    e.word = {cond, 4'hA, {16{t[7]}}, t[7:0]};
                end
            end
            5'd28:
            begin
                e.cls  = CLS_BRANCH;
                e.word = {8'hEA, {13{t[10]}}, t[10:0]};
            end
            default:
            begin
                e.cls  = CLS_NONE;
                e.word = 32'h0;
            end
        endcase
        return e;
    endfunction

endpackage

[hw/rtl/thumb_to_arm_expander.sv]
// Thumb-to-ARM expander top level: input register, expansion logic, result register.
// An accepted item (start high, busy low) is captured in the input register and then in the
// result register; done rises as the result register is loaded, and the result is taken while done is high.
// Throughput: one item per cycle; busy is never raised, as nothing downstream stalls.
// done is high for exactly one cycle per item, with arm_instruction and instruction_class.
// Reset (rst_n low, asynchronous) drops both stage valid flags; items in flight are lost.
// Payload registers are not reset.
module thumb_to_arm_expander
    import tte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] thumb_instruction,
    output logic        done,
    output logic [31:0] arm_instruction,
    output logic [3:0]  instruction_class
);

    // Stage 1: captured Thumb item
    logic        in_vld_reg;
    logic [15:0] in_word_reg;

    // Stage 2: expanded result
    logic        out_vld_reg;
    logic [31:0] out_word_reg;
    cls_t        out_cls_reg;

    expand_t     exp_next;
    logic        accept;

    // The expander never stalls, so an item may be taken every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= accept;
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_word_reg <= thumb_instruction;
    end

    // Format decode from the top five bits, then field moves into ARM positions
    always_comb
    begin
        exp_next = expand(in_word_reg);
    end

    always_ff @(posedge clk)
    begin
        if (in_vld_reg)
        begin
            out_word_reg <= exp_next.word;
            out_cls_reg  <= exp_next.cls;
        end
    end

    assign done              = out_vld_reg;
    assign arm_instruction   = out_word_reg;
    assign instruction_class = out_cls_reg;

`ifndef SYNTH
    // Every accepted item yields its strobe once it has passed both stage registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 done)
        else $error("expander: result strobe missing after accepted item");

    // Unsupported encodings always give a zero word
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (instruction_class == CLS_NONE) |-> (arm_instruction == 32'h0))
        else $error("expander: unsupported item with non-zero word");

    // Multiplies carry the 1001 marker bits
    a_mul_marker: assert property (@(posedge clk) disable iff (!rst_n)
        done && (instruction_class == CLS_MUL) |-> (arm_instruction[7:4] == 4'b1001))
        else $error("expander: multiply without marker bits");

    // No strobe without an item accepted before it passed both stage registers
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 2))
        else $error("expander: strobe without an accepted item");
`endif

endmodule

[test/tb_thumb_to_arm_expander.sv]
// Testbench for the Thumb-to-ARM expander: directed and random items checked by a predictor.
`timescale 1ns / 100ps

module tb_thumb_to_arm_expander;
    import tte_pkg::*;

    // Longest correct quiet spell is a full sender gap plus the pipeline, so this is ample.
    localparam int WATCHDOG_LIMIT = 250;
    // Pipeline depth from the accepting edge to the done strobe, plus some slack.
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_GAP        = 11;

    // One predicted expansion, kept with the Thumb word that caused it for reporting.
    typedef struct {
        logic [15:0] thumb;
        logic [31:0] word;
        cls_t        cls;
    } expansion_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [15:0] thumb_instruction;
    logic        done;
    logic [31:0] arm_instruction;
    logic [3:0]  instruction_class;

    expansion_t  pending_expansions[$];
    int          mismatch_count;
    int          idle_cycles;

    thumb_to_arm_expander dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .thumb_instruction (thumb_instruction),
        .done              (done),
        .arm_instruction   (arm_instruction),
        .instruction_class (instruction_class)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor: decode the format from the top five bits and build the
    // ARM word field by field on top of each format's fixed pattern.
    // ------------------------------------------------------------------
    function automatic expansion_t predict_arm_expansion(input logic [15:0] t);
        expansion_t e;
        logic [4:0] top;
        logic [2:0] rd;
        logic [2:0] rb;
        logic [2:0] ro;
        logic [3:0] alu_op;
        logic [1:0] sub_op;
        logic [3:0] hrs;
        logic [3:0] hrd;
        logic [1:0] sh;
        logic       l;
        top      = t[15:11];
        rd       = t[2:0];
        rb       = t[5:3];
        ro       = t[8:6];
        e.thumb  = t;
        e.word   = 32'h0;
        e.cls    = CLS_NONE;
        case (top)
            // shift by immediate: MOVS Rd, Rm, <shift> #imm5
            5'd0, 5'd1, 5'd2:
            begin
                e.cls          = CLS_ALU;
                e.word         = 32'hE1B00000;
                e.word[14:12]  = rd;
                e.word[11:7]   = t[10:6];
                e.word[6:5]    = top[1:0];
                e.word[2:0]    = rb;
            end
            // add/subtract, register or 3-bit immediate
            5'd3:
            begin
                e.cls          = CLS_ALU;
                e.word         = 32'hE0100000;
                e.word[25]     = t[10];
                e.word[24:21]  = t[9] ? OP_SUB : OP_ADD;
                e.word[18:16]  = rb;
                e.word[14:12]  = rd;
                e.word[2:0]    = ro;
            end
            // MOV/CMP/ADD/SUB with 8-bit immediate
            5'd4, 5'd5, 5'd6, 5'd7:
            begin
                e.cls          = CLS_ALU;
                e.word         = 32'hE2100000;
                case (top[1:0])
                    2'd0:    e.word[24:21] = OP_MOV;
                    2'd1:    e.word[24:21] = OP_CMP;
                    2'd2:    e.word[24:21] = OP_ADD;
                    default: e.word[24:21] = OP_SUB;
                endcase
                e.word[18:16]  = t[10:8];
                e.word[14:12]  = t[10:8];
                e.word[7:0]    = t[7:0];
            end
            5'd8:
            begin
                if (!t[10])
                begin
                    // ALU group
                    alu_op = t[9:6];
                    e.cls  = CLS_ALU;
                    if (alu_op == ALU_LSL || alu_op == ALU_LSR || alu_op == ALU_ASR ||
                        alu_op == ALU_ROR)
                    begin
                        case (alu_op)
                            ALU_LSL: sh = 2'd0;
                            ALU_LSR: sh = 2'd1;
                            ALU_ASR: sh = 2'd2;
                            default: sh = 2'd3;
                        endcase
                        e.word         = 32'hE1B00010;
                        e.word[14:12]  = rd;
                        e.word[10:8]   = rb;
                        e.word[6:5]    = sh;
                        e.word[2:0]    = rd;
                    end
                    else if (alu_op == ALU_NEG)
                    begin
                        // RSBS Rd, Rs, #0
                        e.word         = 32'hE2700000;
                        e.word[18:16]  = rb;
                        e.word[14:12]  = rd;
                    end
                    else if (alu_op == ALU_MUL)
                    begin
                        // MULS Rd, Rs, Rd: Rd in both the destination and Rs slots
                        e.cls          = CLS_MUL;
                        e.word         = 32'hE0100090;
                        e.word[18:16]  = rd;
                        e.word[10:8]   = rd;
                        e.word[2:0]    = rb;
                    end
                    else
                    begin
                        e.word         = 32'hE0100000;
                        e.word[24:21]  = alu_op;
                        e.word[18:16]  = rd;
                        e.word[14:12]  = rd;
                        e.word[2:0]    = rb;
                    end
                end
                else
                begin
                    // hi-register ops and BX; H bits taken as given
                    sub_op = t[9:8];
                    hrs    = {t[6], t[5:3]};
                    hrd    = {t[7], t[2:0]};
                    if (sub_op == 2'd3)
                    begin
                        e.cls         = CLS_BX;
                        e.word        = 32'hE12FFF10;
                        e.word[3:0]   = hrs;
                    end
                    else
                    begin
                        e.cls         = CLS_ALU;
                        e.word        = 32'hE0000000;
                        case (sub_op)
                            2'd0:    e.word[24:21] = OP_ADD;
                            2'd1:    e.word[24:21] = OP_CMP;
                            default: e.word[24:21] = OP_MOV;
                        endcase
                        e.word[20]    = (sub_op == 2'd1);
                        e.word[19:16] = hrd;
                        e.word[15:12] = hrd;
                        e.word[3:0]   = hrs;
                    end
                end
            end
            // load/store with register offset, word/byte or halfword/signed
            5'd10, 5'd11:
            begin
                if (!t[9])
                begin
                    e.cls          = CLS_SINGLE;
                    e.word         = 32'hE7800000;
                    e.word[22]     = t[10];
                    e.word[20]     = t[11];
                end
                else
                begin
                    sub_op = t[11:10];
                    case (sub_op)
                        2'd0:    sh = 2'd1;
                        2'd1:    sh = 2'd2;
                        2'd2:    sh = 2'd1;
                        default: sh = 2'd3;
                    endcase
                    e.cls          = CLS_HALF;
                    e.word         = 32'hE1800090;
                    e.word[20]     = (sub_op != 2'd0);
                    e.word[6:5]    = sh;
                end
                e.word[18:16] = rb;
                e.word[14:12] = rd;
                e.word[2:0]   = ro;
            end
            // load/store immediate offset; word offsets scaled by four
            5'd12, 5'd13, 5'd14, 5'd15:
            begin
                e.cls          = CLS_SINGLE;
                e.word         = 32'hE5800000;
                e.word[22]     = t[12];
                e.word[20]     = t[11];
                e.word[18:16]  = rb;
                e.word[14:12]  = rd;
                e.word[6:0]    = t[12] ? {2'b00, t[10:6]} : {t[10:6], 2'b00};
            end
            // halfword immediate: offset*2 split across the two nibble fields
            5'd16, 5'd17:
            begin
                e.cls          = CLS_HALF;
                e.word         = 32'hE1C000B0;
                e.word[20]     = t[11];
                e.word[18:16]  = rb;
                e.word[14:12]  = rd;
                e.word[9:8]    = t[10:9];
                e.word[3:0]    = {t[8:6], 1'b0};
            end
            // SP-relative load/store
            5'd18, 5'd19:
            begin
                e.cls          = CLS_SINGLE;
                e.word         = 32'hE58D0000;
                e.word[20]     = t[11];
                e.word[14:12]  = t[10:8];
                e.word[9:2]    = t[7:0];
            end
            5'd22, 5'd23:
            begin
                if (t[11:8] == 4'h0)
                begin
                    // SP adjust: bit 7 selects SUB over ADD
                    e.cls          = CLS_ALU;
                    e.word         = 32'hE20DDF00;
                    e.word[24:21]  = t[7] ? OP_SUB : OP_ADD;
                    e.word[6:0]    = t[6:0];
                end
                else if (t[10:9] == 2'b10)
                begin
                    // push and pop; the extra register is LR for push, PC for pop
                    l              = t[11];
                    e.cls          = CLS_BLOCK;
                    e.word         = 32'hE82D0000;
                    e.word[24]     = ~l;
                    e.word[23]     = l;
                    e.word[20]     = l;
                    e.word[7:0]    = t[7:0];
                    if (l)
                        e.word[15] = t[8];
                    else
                        e.word[14] = t[8];
                end
            end
            // load/store multiple, increment after with writeback
            5'd24, 5'd25:
            begin
                e.cls          = CLS_BLOCK;
                e.word         = 32'hE8A00000;
                e.word[20]     = t[11];
                e.word[18:16]  = t[10:8];
                e.word[7:0]    = t[7:0];
            end
            // conditional branch and SWI; the never condition stays unsupported
            5'd26, 5'd27:
            begin
                if (t[11:8] == COND_SWI)
                begin
                    e.cls          = CLS_SWI;
                    e.word         = 32'hEF000000;
                    e.word[7:0]    = t[7:0];
                end
                else if (t[11:8] != COND_NEVER)
                begin
                    e.cls          = CLS_BRANCH;
                    e.word         = {t[11:8], 4'hA, {16{t[7]}}, t[7:0]};
                end
            end
            // unconditional branch, offset sign-extended but not rescaled
            5'd28:
            begin
                e.cls          = CLS_BRANCH;
                e.word         = {8'hEA, {13{t[10]}}, t[10:0]};
            end
            default:
            begin
                e.cls          = CLS_NONE;
                e.word         = 32'h0;
            end
        endcase
        return e;
    endfunction

    // ------------------------------------------------------------------
    // Reporting and checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Results cannot be held off, so every done cycle is an accepted result.
    always @(posedge clk)
    begin
        expansion_t exp_item;
        if (rst_n && done)
        begin
            if (pending_expansions.size() == 0)
                report_mismatch($sformatf("unexpected result word %08h class %0d",
                                          arm_instruction, instruction_class));
            else
            begin
                exp_item = pending_expansions.pop_front();
                if (arm_instruction !== exp_item.word)
                    report_mismatch($sformatf("thumb %04h: arm_instruction %08h, expected %08h",
                                              exp_item.thumb, arm_instruction, exp_item.word));
                if (instruction_class !== exp_item.cls)
                    report_mismatch($sformatf("thumb %04h: instruction_class %0d, expected %0d",
                                              exp_item.thumb, instruction_class, exp_item.cls));
            end
        end
    end

    // Watchdog: any quiet spell longer than the limit means the block has hung.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Drive one item at the falling edge after an optional gap, hold it until the
    // block takes it, then queue its predicted expansion.
    task automatic send_item(input logic [15:0] thumb, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, MAX_GAP);
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start             <= 1'b1;
        thumb_instruction <= thumb;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_expansions.push_back(predict_arm_expansion(thumb));
    endtask

    // Random word biased towards the crowded corners of the encoding map.
    function automatic logic [15:0] random_thumb_word();
        logic [31:0] r;
        logic [3:0]  sel;
        r = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2: return r[15:0];
            3:       return {5'b01000, r[10:0]};          // ALU group and hi-register ops
            4:
            begin
                // misc space: SP adjust, push, pop, and the leftovers
                case ($urandom_range(0, 3))
                    0:       sel = 4'h0;
                    1:       sel = {3'b010, r[8]};
                    2:       sel = {3'b110, r[8]};
                    default: sel = r[11:8];
                endcase
                return {4'b1011, sel, r[7:0]};
            end
            5:       return {4'b1101, r[11:0]};           // conditional branch / SWI
            6:       return {3'b010, r[12:0]};            // top 8-11: ALU, reg offset
            default: return r[15:0];
        endcase
    endfunction

    task automatic test_format_coverage();
        logic [15:0] words[$];
        words = '{16'h0000, 16'h17FF, 16'h1FFF, 16'h20FF, 16'h3FFF, 16'h41C0, 16'h5FFF,
                  16'h5200, 16'h7FFF, 16'h8FFF, 16'h9FFF, 16'hCFFF, 16'hE400};
        foreach (words[i])
            send_item(words[i], 1'b0);
    endtask

    // Unsupported forms, MUL, NEG, SP adjust both ways, odd H-bit combinations,
    // BX with H1 set, SWI, branch sign extension, push and pop with the extra register.
    task automatic test_special_encodings();
        logic [15:0] words[$];
        words = '{16'hFFFF, 16'h4800, 16'hA000, 16'hDE00, 16'hB100, 16'hE800, 16'h4340,
                  16'h4240, 16'hB07F, 16'hB0FF, 16'h4400, 16'h46FF, 16'h4780, 16'hDFFF,
                  16'hD880, 16'hB5FF, 16'hBDFF};
        foreach (words[i])
            send_item(words[i], 1'b0);
    endtask

    // Random items; every so often a stretch goes back to back with no gaps.
    task automatic test_random_mix(input int count);
        bit burst;
        burst = 1'b0;
        for (int i = 0; i < count; i++)
        begin
            if (i % 25 == 0)
                burst = ($urandom_range(0, 3) == 0);
            send_item(random_thumb_word(), burst);
        end
    endtask

    // Sender stops until the pipeline has emptied, then resumes.
    task automatic test_sender_pause();
        @(negedge clk);
        start <= 1'b0;
        while (pending_expansions.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n             = 1'b0;
        start             = 1'b0;
        thumb_instruction = 16'h0000;
        mismatch_count    = 0;
        idle_cycles       = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_format_coverage();
        test_special_encodings();
        test_random_mix(150);
        test_sender_pause();
        test_random_mix(150);
        test_sender_pause();
        test_random_mix(150);

        @(negedge clk);
        start <= 1'b0;
        while (pending_expansions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
